@@ src/lag_pkg.sv @@
// Shared types and constants of the life automaton generation block.
package lag_pkg;

  // Field widths of the stream payloads
  localparam int MODE_W      = 2;
  localparam int FIELD_W     = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Configuration register port
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;
  localparam logic REG_ROWS    = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  // B3/S23 neighbor counts
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;

  // Operation selected by an input transaction
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_UPD,
    ST_STEP,
    ST_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_req;
    logic step_start;
    logic cell_read;
    logic cell_update;
    logic step_run;
    logic flip_bank;
    logic load_result;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    mode_t in_mode;
    logic  step_done;
    logic  out_free;
  } status_t;

endpackage

@@ src/lag_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lag_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/lag_ctrl.sv @@
// Controller state machine: sequences cell accesses and generation steps.
module lag_ctrl
  import lag_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (status.in_mode)
            MODE_WRITE: state_nxt = ST_CELL_RD;
            MODE_READ:  state_nxt = ST_CELL_RD;
            MODE_STEP:  state_nxt = ST_STEP;
            default:    state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CELL_RD:  state_nxt = ST_CELL_UPD;
      ST_CELL_UPD: state_nxt = ST_RESULT;
      ST_STEP: begin
        if (status.step_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.latch_req  = in_tvalid;
        cmd.step_start = in_tvalid && (status.in_mode == MODE_STEP);
      end
      ST_CELL_RD:  cmd.cell_read = 1'b1;
      ST_CELL_UPD: cmd.cell_update = 1'b1;
      ST_STEP: begin
        cmd.step_run  = 1'b1;
        cmd.flip_bank = status.step_done;
      end
      ST_RESULT:   cmd.load_result = status.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/lag_datapath.sv @@
// Datapath: grid banks, row window, life rule, config and result registers.
module lag_datapath
  import lag_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLUMNS);
  localparam int SCW = $clog2(MAX_ROWS + 2);
  localparam int RCW = (SCW > CFG_W) ? SCW : CFG_W;
  localparam int CCW = ($clog2(MAX_COLUMNS + 1) > CFG_W) ? $clog2(MAX_COLUMNS + 1) : CFG_W;

  // Configuration
  logic [CFG_W-1:0] rows_cfg_r;
  logic [CFG_W-1:0] cols_cfg_r;

  // Latched request
  mode_t              mode_r;
  logic [FIELD_W-1:0] row_r;
  logic [FIELD_W-1:0] col_r;
  logic               alive_in_r;

  // Bank state
  logic                   bank_r;
  logic [MAX_ROWS-1:0]    valid0_r;
  logic                   rd_valid0_r;
  logic [MAX_COLUMNS-1:0] rd0;
  logic [MAX_COLUMNS-1:0] rd1;
  logic [MAX_COLUMNS-1:0] cur_row;

  // Step walk
  logic [SCW-1:0]         cnt_r;
  logic [MAX_COLUMNS-1:0] top_r;
  logic [MAX_COLUMNS-1:0] mid_r;
  logic [MAX_COLUMNS-1:0] in_row;
  logic [MAX_COLUMNS-1:0] new_row;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [RCW-1:0]         data_row;
  logic [RCW-1:0]         out_row;
  logic                   step_wr;

  // Cell access
  logic [RCW-1:0]         nr;
  logic [CCW-1:0]         nc;
  logic                   in_grid;
  logic [CAW-1:0]         col_idx;
  logic [MAX_COLUMNS-1:0] upd_row;
  logic                   cell_wr;
  logic                   alive_r;

  // Memory ports
  logic [RAW-1:0]         rd_addr;
  logic [RAW-1:0]         wr_addr;
  logic [MAX_COLUMNS-1:0] wr_data;
  logic                   we0;
  logic                   we1;

  // Result register
  logic out_tvalid_r;
  logic out_alive_r;
  logic out_done_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_SIZE_RESET;
      cols_cfg_r <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:    rows_cfg_r <= cfg_wdata;
        REG_COLUMNS: cols_cfg_r <= cfg_wdata;
        default:     rows_cfg_r <= rows_cfg_r;
      endcase
    end
  end

  // Sizes in use, saturated to the grid dimensions
  always_comb begin
    nr = (RCW'(rows_cfg_r) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_r);
    nc = (CCW'(cols_cfg_r) > CCW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : CCW'(cols_cfg_r);
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = CCW'(c) < nc;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      mode_r     <= mode_t'(in_tdata[MODE_W-1:0]);
      row_r      <= in_tdata[MODE_W +: FIELD_W];
      col_r      <= in_tdata[MODE_W+FIELD_W +: FIELD_W];
      alive_in_r <= in_tdata[MODE_W+2*FIELD_W];
    end
  end

  assign in_grid = (RCW'(row_r) < nr) && (CCW'(col_r) < nc);
  assign col_idx = CAW'(col_r);

  // Row read from the current bank; bank 0 rows read dead until written
  assign rd_addr = cmd.cell_read ? RAW'(row_r) : cnt_r[RAW-1:0];
  assign cur_row = bank_r ? rd1 : (rd0 & {MAX_COLUMNS{rd_valid0_r}});

  always_ff @(posedge clk) begin
    rd_valid0_r <= valid0_r[rd_addr];
  end

  // Single cell read-modify-write
  always_comb begin
    upd_row          = cur_row;
    upd_row[col_idx] = alive_in_r;
  end

  assign cell_wr = cmd.cell_update && (mode_r == MODE_WRITE) && in_grid;

  always_ff @(posedge clk) begin
    if (cmd.cell_update) begin
      alive_r <= (mode_r == MODE_READ) && in_grid && cur_row[col_idx];
    end
  end

  // Step walk: counter and three-row window
  assign data_row = RCW'(cnt_r) - RCW'(1);
  assign out_row  = RCW'(cnt_r) - RCW'(2);
  assign in_row   = (data_row < nr) ? (cur_row & col_mask) : '0;
  assign step_wr  = cmd.step_run && (cnt_r >= SCW'(2));

  always_ff @(posedge clk) begin
    if (cmd.step_start) begin
      cnt_r <= '0;
      top_r <= '0;
      mid_r <= '0;
    end else if (cmd.step_run) begin
      cnt_r <= cnt_r + SCW'(1);
      if (cnt_r != '0) begin
        top_r <= mid_r;
        mid_r <= in_row;
      end
    end
  end

  // B3/S23 rule over one row, each column independent
  always_comb begin : life_rule
    logic [MAX_COLUMNS+1:0] tp;
    logic [MAX_COLUMNS+1:0] md;
    logic [MAX_COLUMNS+1:0] bt;
    logic [3:0]             n;
    tp = {1'b0, top_r, 1'b0};
    md = {1'b0, mid_r, 1'b0};
    bt = {1'b0, in_row, 1'b0};
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      n = 4'(tp[c]) + 4'(tp[c+1]) + 4'(tp[c+2])
        + 4'(md[c]) + 4'(md[c+2])
        + 4'(bt[c]) + 4'(bt[c+1]) + 4'(bt[c+2]);
      new_row[c] = col_mask[c] && (out_row < nr)
                   && ((n == BIRTH_COUNT) || (md[c+1] && (n == SURVIVE_COUNT)));
    end
  end

  // Write port steering: cells go to the current bank, steps to the other
  assign we0     = (cell_wr && !bank_r) || (step_wr && bank_r);
  assign we1     = (cell_wr && bank_r) || (step_wr && !bank_r);
  assign wr_addr = cell_wr ? RAW'(row_r) : out_row[RAW-1:0];
  assign wr_data = cell_wr ? upd_row : new_row;

  // Bank select and bank 0 row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      valid0_r <= '0;
    end else begin
      if (cmd.flip_bank) begin
        bank_r <= ~bank_r;
      end
      if (we0) begin
        valid0_r[wr_addr] <= 1'b1;
      end
    end
  end

  lag_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd0)
  );

  lag_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd1)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_alive_r <= (mode_r == MODE_READ) && alive_r;
      out_done_r  <= (mode_r != MODE_NONE);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_done_r, out_alive_r};

  // Status
  assign status.in_mode   = mode_t'(in_tdata[MODE_W-1:0]);
  assign status.step_done = (cnt_r == SCW'(MAX_ROWS + 1));
  assign status.out_free  = !out_tvalid_r || out_tready;

endmodule

@@ src/life_automaton_generation.sv @@
// Top level of the B3/S23 life automaton block: controller plus datapath.
//
// The block holds a MAX_ROWS x MAX_COLUMNS cell grid in two row-wide RAM
// banks and takes one transaction at a time. A cell write or read passes
// from acceptance to the result register through request latch, row read,
// row update and result. A generation step walks the grid one row per cycle
// through the single read port of the current bank. Rows outside the
// configured size and columns outside it are dead and never counted. Bank 0
// reads as all dead after reset through per-row valid bits, so no clearing
// pass is needed. The controller is freed as soon as its result is loaded
// into the result register. Configuration is to be written only while idle;
// the block itself does not enforce it.
module life_automaton_generation
  import lag_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // mode[1:0], row[7:2], column[13:8], alive_in[14]
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // alive_out[0], done_res[1]
);

  cmd_t    cmd;
  status_t status;

  lag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lag_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // A result is never loaded over one that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> status.out_free)
    else $error("result loaded while output register busy");

  // One transaction at a time: acceptance closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while previous transaction in flight");

  // A row update always follows its row read
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cell_update |-> $past(cmd.cell_read))
    else $error("cell update without preceding row read");
`endif

endmodule
